// ===== rtl/joint_command_limit_envelope_assert.svh =====
// ----------------------------------------------------------------------------
// Joint limit envelope assertion macros
// Shared concurrent assertion forms for the envelope checker.
// ----------------------------------------------------------------------------
`ifndef JOINT_COMMAND_LIMIT_ENVELOPE_ASSERT_SVH
`define JOINT_COMMAND_LIMIT_ENVELOPE_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define JCLE_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("envelope check failed");

// condition holds in the cycle after the trigger
`define JCLE_IMPLIES_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("envelope check failed");

`endif

// ===== rtl/jcle_pkg.sv =====
// ----------------------------------------------------------------------------
// Joint limit envelope package
// Types, constants and arithmetic helpers for the envelope pipeline.
// ----------------------------------------------------------------------------
package jcle_pkg;

   localparam int FRONT_STAGES = 8;
   localparam int DIV_STEPS    = 47;
   localparam int NUM_STAGES   = FRONT_STAGES + DIV_STEPS + 2;

   localparam logic signed [47:0] VMAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] VMIN = 48'sh8000_0000_0000;

   localparam logic signed [49:0] FAULT_TOL  = 50'sd16777;
   localparam logic signed [49:0] BOUNDS_TOL = 50'sd16777;
   localparam logic [46:0]        PERIOD_RESET = 47'd16777;

   localparam int EN_POS = 0;
   localparam int EN_VEL = 1;
   localparam int EN_ACC = 2;
   localparam int EN_DEC = 3;
   localparam int EN_EFF = 4;

   typedef enum logic [2:0] {
      REG_MIN_POS,
      REG_MAX_POS,
      REG_MAX_VEL,
      REG_MAX_ACC,
      REG_MAX_DEC,
      REG_MAX_EFF,
      REG_PERIOD,
      REG_ENABLES
   } reg_idx_type;

   typedef struct packed {
      logic [45:0] hh;
      logic [46:0] hl;
      logic [46:0] lh;
      logic [47:0] ll;
   } pp_type;

   typedef struct packed {
      logic        sgn;
      logic        zq;
      logic        sat;
      logic [46:0] rem;
      logic [46:0] quo;
      logic [46:0] bits;
   } lane_type;

   typedef struct packed {
      logic               fault;
      logic               zero_v;
      logic               pv;
      logic               lvv;
      logic signed [47:0] lpos;
      logic signed [47:0] lvel;
      logic signed [47:0] elo;
      logic signed [47:0] ehi;
      logic signed [47:0] alo;
      logic signed [47:0] ahi;
      logic signed [47:0] plo;
      logic signed [47:0] phi;
      logic signed [47:0] vlo;
      logic signed [47:0] vhi;
      logic signed [48:0] dlo;
      logic signed [48:0] dhi;
      logic signed [48:0] va_lo;
      logic signed [48:0] va_hi;
      logic signed [48:0] ns_lo;
      logic signed [48:0] ns_hi;
      logic [47:0]        avabs;
      pp_type             pp;
      logic [46:0]        dv;
      logic [46:0]        dvel;
      logic [46:0]        mv;
      logic [46:0]        dp;
      lane_type           lo;
      lane_type           hi;
   } pipe_type;

   function automatic pp_type qmul_parts(input logic [46:0] a, input logic [46:0] b);
      pp_type p;
      p.hh = a[46:24] * b[46:24];
      p.hl = a[46:24] * b[23:0];
      p.lh = a[23:0] * b[46:24];
      p.ll = a[23:0] * b[23:0];
      return p;
   endfunction

   function automatic logic [46:0] qmul_join(input pp_type p);
      logic [48:0] s;
      s = 49'({p.hh[22:0], 24'd0}) + 49'(p.hl) + 49'(p.lh) + 49'(p.ll[47:24]);
      if ((p.hh[45:23] != '0) || (s[48:47] != 2'b00))
         return '1;
      return s[46:0];
   endfunction

   function automatic lane_type lane_init(input logic signed [48:0] diff,
                                          input logic [46:0] d);
      lane_type    l;
      logic [48:0] mag;
      mag    = diff[48] ? 49'(-diff) : 49'(diff);
      l.sgn  = diff[48];
      l.zq   = (mag == '0);
      l.sat  = (47'(mag[47:23]) >= d);
      l.rem  = 47'(mag[47:23]);
      l.quo  = '0;
      l.bits = {mag[22:0], 24'd0};
      return l;
   endfunction

   function automatic lane_type lane_step(input lane_type l, input logic [46:0] d);
      lane_type    n;
      logic [47:0] r;
      logic        ge;
      r      = {l.rem, l.bits[46]};
      ge     = (r >= {1'b0, d});
      n      = l;
      n.rem  = ge ? 47'(r - {1'b0, d}) : r[46:0];
      n.quo  = {l.quo[45:0], ge};
      n.bits = {l.bits[45:0], 1'b0};
      return n;
   endfunction

   function automatic logic signed [47:0] lane_result(input lane_type l);
      logic signed [47:0] qs;
      qs = $signed({1'b0, l.quo});
      if (l.zq)
         return '0;
      if (l.sat)
         return l.sgn ? VMIN : VMAX;
      return l.sgn ? -qs : qs;
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [48:0] v);
      if (v > 49'(VMAX))
         return VMAX;
      if (v < 49'(VMIN))
         return VMIN;
      return v[47:0];
   endfunction

endpackage

// ===== rtl/joint_command_limit_envelope.sv =====
// ----------------------------------------------------------------------------
// Joint command limit envelope
// Per-sample position, velocity, effort and acceleration bounds for a joint.
// ----------------------------------------------------------------------------
// Channels: req_* carries one joint sample per item, rsp_* returns one set of
// bounds plus the position fault flag per item, csr_* writes the limit
// registers by index (always ready; write only while no item is in flight).
// Throughput: one item per cycle while the receiver takes results. The
// pipeline is the restoring divide of position headroom by the period, which
// produces one quotient bit per stage over 47 stages, behind eight front
// stages for the two fixed-point products, and two clamp stages.
// Every stage holds a valid bit; a stage that is empty loads even while the
// receiver stalls, so bubbles close up and req_ready stays high while the
// first stage is free. A stalled result holds on rsp_* until taken.
// Reset empties the pipeline and returns registers to their defaults
// (period 16777, all others zero, all limits disabled).
// ----------------------------------------------------------------------------
module joint_command_limit_envelope
   import jcle_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [47:0]        csr_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [47:0] req_actual_position,
   input  logic               req_position_valid,
   input  logic signed [47:0] req_actual_velocity,
   input  logic               req_velocity_valid,
   input  logic signed [47:0] req_last_cmd_position,
   input  logic signed [47:0] req_last_cmd_velocity,
   input  logic               req_last_velocity_valid,
   input  logic signed [47:0] req_wanted_velocity,
   input  logic signed [47:0] req_wanted_acceleration,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [47:0] rsp_pos_low,
   output logic signed [47:0] rsp_pos_high,
   output logic signed [47:0] rsp_vel_low,
   output logic signed [47:0] rsp_vel_high,
   output logic signed [47:0] rsp_eff_low,
   output logic signed [47:0] rsp_eff_high,
   output logic signed [47:0] rsp_acc_low,
   output logic signed [47:0] rsp_acc_high,
   output logic               rsp_position_fault
);

   localparam int LAST = NUM_STAGES - 1;
   localparam int POST = FRONT_STAGES + DIV_STEPS;

   logic signed [47:0] minpos_ff, maxpos_ff;
   logic [46:0]        maxvel_ff, maxacc_ff, maxdec_ff, maxeff_ff, period_ff;
   logic [4:0]         en_ff;

   pipe_type           pl_ff [NUM_STAGES];
   pipe_type           pl_in [NUM_STAGES];
   logic [LAST:0]      v_ff;
   logic [LAST:0]      take;
   logic [LAST:0]      upv;
   logic [LAST:0]      down_take;
   logic               adv;

   logic signed [49:0] ap, av, mn, mx, wv, wa, mvel;
   logic               out_pos, near;
   logic [48:0]        sum49;
   logic signed [48:0] mn49, mx49, tmin, tmax, tlo, thi;
   logic signed [47:0] qlo, qhi;
   logic signed [48:0] va, vb;
   logic signed [47:0] slo, shi;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         minpos_ff <= '0;
         maxpos_ff <= '0;
         maxvel_ff <= '0;
         maxacc_ff <= '0;
         maxdec_ff <= '0;
         maxeff_ff <= '0;
         period_ff <= PERIOD_RESET;
         en_ff     <= '0;
      end else if (csr_valid) begin
         case (reg_idx_type'(csr_index))
            REG_MIN_POS: minpos_ff <= csr_data;
            REG_MAX_POS: maxpos_ff <= csr_data;
            REG_MAX_VEL: maxvel_ff <= csr_data[46:0];
            REG_MAX_ACC: maxacc_ff <= csr_data[46:0];
            REG_MAX_DEC: maxdec_ff <= csr_data[46:0];
            REG_MAX_EFF: maxeff_ff <= csr_data[46:0];
            REG_PERIOD:  period_ff <= csr_data[46:0];
            REG_ENABLES: en_ff     <= csr_data[4:0];
            default: ;
         endcase
      end
   end

   // handshake: a stage loads when empty or when the whole line advances
   assign adv       = !v_ff[LAST] || rsp_ready;
   assign req_ready = take[0];
   assign rsp_valid = v_ff[LAST];

   always_comb begin
      for (int s = 0; s < NUM_STAGES; s++) begin
         take[s]      = !v_ff[s] || adv;
         upv[s]       = (s == 0) ? req_valid : v_ff[(s == 0) ? 0 : s - 1];
         down_take[s] = (s == LAST) ? 1'b0 : take[(s == LAST) ? LAST : s + 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int s = 0; s < NUM_STAGES; s++) begin
            if (take[s])
               v_ff[s] <= upv[s];
            else if (down_take[s])
               v_ff[s] <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < NUM_STAGES; s++) begin
         if (take[s])
            pl_ff[s] <= pl_in[s];
      end
   end

   // sample checks, effort and acceleration bounds, position headroom, first product terms
   always_comb begin
      ap   = 50'(req_actual_position);
      av   = 50'(req_actual_velocity);
      wv   = 50'(req_wanted_velocity);
      wa   = 50'(req_wanted_acceleration);
      mn   = 50'(minpos_ff);
      mx   = 50'(maxpos_ff);
      mvel = $signed({3'b000, maxvel_ff});

      pl_in[0]       = '0;
      pl_in[0].lpos  = req_last_cmd_position;
      pl_in[0].lvel  = req_last_cmd_velocity;
      pl_in[0].lvv   = req_last_velocity_valid;
      pl_in[0].pv    = req_position_valid;
      pl_in[0].fault = en_ff[EN_POS] && req_position_valid &&
                       ((ap > mx + FAULT_TOL) || (ap < mn - FAULT_TOL));

      out_pos = (ap > mx) || (ap < mn);
      near    = ((ap < mx + BOUNDS_TOL) && (ap > mn) && (wv >= 50'sd0)) ||
                ((ap > mn - BOUNDS_TOL) && (ap < mx) && (wv <= 50'sd0)) ||
                (ap > mx + BOUNDS_TOL) || (ap < mn - BOUNDS_TOL);
      pl_in[0].zero_v = en_ff[EN_POS] && req_position_valid && out_pos && near;

      pl_in[0].ehi = en_ff[EN_EFF] ? $signed({1'b0, maxeff_ff}) : VMAX;
      pl_in[0].elo = en_ff[EN_EFF] ? -$signed({1'b0, maxeff_ff}) : VMIN;
      if (en_ff[EN_POS] && req_position_valid && req_velocity_valid) begin
         if ((ap <= mn) && (av <= 50'sd0))
            pl_in[0].elo = '0;
         else if ((ap >= mx) && (av >= 50'sd0))
            pl_in[0].ehi = '0;
      end
      if (en_ff[EN_VEL] && req_velocity_valid) begin
         if (av < -mvel)
            pl_in[0].elo = '0;
         else if (av > mvel)
            pl_in[0].ehi = '0;
      end

      if (en_ff[EN_DEC] && req_velocity_valid &&
          (((wa < 50'sd0) && (av > 50'sd0)) || ((wa > 50'sd0) && (av < 50'sd0)))) begin
         pl_in[0].alo = -$signed({1'b0, maxdec_ff});
         pl_in[0].ahi = $signed({1'b0, maxdec_ff});
      end else if (en_ff[EN_ACC]) begin
         pl_in[0].alo = -$signed({1'b0, maxacc_ff});
         pl_in[0].ahi = $signed({1'b0, maxacc_ff});
      end else begin
         pl_in[0].alo = VMIN;
         pl_in[0].ahi = VMAX;
      end

      pl_in[0].dlo   = 49'(mn - ap);
      pl_in[0].dhi   = 49'(mx - ap);
      pl_in[0].avabs = req_velocity_valid ? 48'((av < 50'sd0) ? -av : av) : '0;
      pl_in[0].pp    = qmul_parts(maxacc_ff, period_ff);
   end

   // velocity step per period, divider set-up
   always_comb begin
      pl_in[1]    = pl_ff[0];
      pl_in[1].dv = qmul_join(pl_ff[0].pp);
      pl_in[1].lo = lane_init(pl_ff[0].dlo, period_ff);
      pl_in[1].hi = lane_init(pl_ff[0].dhi, period_ff);
   end

   always_comb begin
      pl_in[2]       = pl_ff[1];
      sum49          = {1'b0, pl_ff[1].avabs} + {2'b00, pl_ff[1].dv};
      pl_in[2].dvel  = en_ff[EN_ACC] ?
                       ((sum49 > {2'b00, {47{1'b1}}}) ? '1 : sum49[46:0]) : maxvel_ff;
      pl_in[2].va_lo = 49'($signed(pl_ff[1].lvel)) - $signed({2'b00, pl_ff[1].dv});
      pl_in[2].va_hi = 49'($signed(pl_ff[1].lvel)) + $signed({2'b00, pl_ff[1].dv});
   end

   always_comb begin
      pl_in[3]    = pl_ff[2];
      pl_in[3].mv = (maxvel_ff < pl_ff[2].dvel) ? maxvel_ff : pl_ff[2].dvel;
   end

   always_comb begin
      pl_in[4]    = pl_ff[3];
      pl_in[4].pp = qmul_parts(pl_ff[3].mv, period_ff);
   end

   always_comb begin
      pl_in[5]    = pl_ff[4];
      pl_in[5].dp = qmul_join(pl_ff[4].pp);
   end

   always_comb begin
      pl_in[6]       = pl_ff[5];
      pl_in[6].ns_lo = 49'($signed(pl_ff[5].lpos)) - $signed({2'b00, pl_ff[5].dp});
      pl_in[6].ns_hi = 49'($signed(pl_ff[5].lpos)) + $signed({2'b00, pl_ff[5].dp});
   end

   // position bounds: clamp the reachable window into the limits when velocity limiting is on, then order
   always_comb begin
      pl_in[7] = pl_ff[6];
      mn49     = 49'(minpos_ff);
      mx49     = 49'(maxpos_ff);
      tmin     = (pl_ff[6].ns_lo < mx49) ? pl_ff[6].ns_lo : mx49;
      tmax     = (pl_ff[6].ns_hi > mn49) ? pl_ff[6].ns_hi : mn49;
      if (en_ff[EN_VEL]) begin
         tlo = (tmin > mn49) ? tmin : mn49;
         thi = (tmax < mx49) ? tmax : mx49;
      end else begin
         tlo = mn49;
         thi = mx49;
      end
      if (tlo > thi) begin
         pl_in[7].plo = thi[47:0];
         pl_in[7].phi = tlo[47:0];
      end else begin
         pl_in[7].plo = tlo[47:0];
         pl_in[7].phi = thi[47:0];
      end
   end

   // one quotient bit per stage for both headroom quotients
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
      always_comb begin
         pl_in[FRONT_STAGES + k]    = pl_ff[FRONT_STAGES + k - 1];
         pl_in[FRONT_STAGES + k].lo = lane_step(pl_ff[FRONT_STAGES + k - 1].lo, period_ff);
         pl_in[FRONT_STAGES + k].hi = lane_step(pl_ff[FRONT_STAGES + k - 1].hi, period_ff);
      end
   end

   always_comb begin
      pl_in[POST]     = pl_ff[POST - 1];
      qlo             = lane_result(pl_ff[POST - 1].lo);
      qhi             = lane_result(pl_ff[POST - 1].hi);
      pl_in[POST].vlo = en_ff[EN_VEL] ? -$signed({1'b0, maxvel_ff}) : VMIN;
      pl_in[POST].vhi = en_ff[EN_VEL] ? $signed({1'b0, maxvel_ff}) : VMAX;
      if (en_ff[EN_POS] && pl_ff[POST - 1].pv) begin
         if (qlo > pl_in[POST].vlo)
            pl_in[POST].vlo = qlo;
         if (qhi < pl_in[POST].vhi)
            pl_in[POST].vhi = qhi;
      end
      if (pl_ff[POST - 1].zero_v) begin
         pl_in[POST].vlo = '0;
         pl_in[POST].vhi = '0;
      end
   end

   always_comb begin
      pl_in[LAST] = pl_ff[LAST - 1];
      slo         = pl_ff[LAST - 1].vlo;
      shi         = pl_ff[LAST - 1].vhi;
      va          = 49'($signed(pl_ff[LAST - 1].vlo));
      vb          = 49'($signed(pl_ff[LAST - 1].vhi));
      if (en_ff[EN_ACC] && pl_ff[LAST - 1].lvv) begin
         slo = sat48((pl_ff[LAST - 1].va_lo > va) ? pl_ff[LAST - 1].va_lo : va);
         shi = sat48((pl_ff[LAST - 1].va_hi < vb) ? pl_ff[LAST - 1].va_hi : vb);
      end
      if (slo > shi) begin
         pl_in[LAST].vlo = shi;
         pl_in[LAST].vhi = slo;
      end else begin
         pl_in[LAST].vlo = slo;
         pl_in[LAST].vhi = shi;
      end
   end

   assign rsp_pos_low        = pl_ff[LAST].plo;
   assign rsp_pos_high       = pl_ff[LAST].phi;
   assign rsp_vel_low        = pl_ff[LAST].vlo;
   assign rsp_vel_high       = pl_ff[LAST].vhi;
   assign rsp_eff_low        = pl_ff[LAST].elo;
   assign rsp_eff_high       = pl_ff[LAST].ehi;
   assign rsp_acc_low        = pl_ff[LAST].alo;
   assign rsp_acc_high       = pl_ff[LAST].ahi;
   assign rsp_position_fault = pl_ff[LAST].fault;

endmodule

// ===== rtl/jcle_checker.sv =====
// ----------------------------------------------------------------------------
// Joint limit envelope checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "joint_command_limit_envelope_assert.svh"

module jcle_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [47:0] rsp_pos_low,
   input logic signed [47:0] rsp_pos_high,
   input logic signed [47:0] rsp_vel_low,
   input logic signed [47:0] rsp_vel_high,
   input logic signed [47:0] rsp_eff_low,
   input logic signed [47:0] rsp_eff_high,
   input logic signed [47:0] rsp_acc_low,
   input logic signed [47:0] rsp_acc_high,
   input logic               rsp_position_fault
);

   `JCLE_IMPLIES_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pos_low) && $stable(rsp_vel_high) && $stable(rsp_position_fault))

   `JCLE_IMPLIES(a_bounds_ordered, clock, reset, rsp_valid, (rsp_pos_low <= rsp_pos_high) && (rsp_vel_low <= rsp_vel_high) && (rsp_eff_low <= rsp_eff_high) && (rsp_acc_low <= rsp_acc_high))

   `JCLE_IMPLIES(a_zero_bracketed, clock, reset, rsp_valid, (rsp_eff_low <= 48'sd0) && (rsp_eff_high >= 48'sd0) && (rsp_acc_low <= 48'sd0) && (rsp_acc_high >= 48'sd0))

endmodule

bind joint_command_limit_envelope jcle_checker u_jcle_checker (.*);

// ===== verif/joint_command_limit_envelope_tb.sv =====
// ----------------------------------------------------------------------------
// Joint command limit envelope testbench
// Drives joint samples under several limit settings, predicts each set of
// bounds and the fault flag in-bench, and checks every returned item against
// the oldest prediction while both channels idle and stall at random.
// ----------------------------------------------------------------------------
module joint_command_limit_envelope_tb
   import jcle_pkg::*;
();

   localparam longint Q_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint Q_MIN   = -64'sh0000_8000_0000_0000;
   localparam longint MAG_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint FAULT_MARGIN  = 16777;
   localparam longint BOUNDS_MARGIN = 16777;
   localparam int     DRAIN_CYCLES  = 80;

   typedef struct {
      longint apos;
      bit     pv;
      longint avel;
      bit     vv;
      longint lpos;
      longint lvel;
      bit     lvv;
      longint wvel;
      longint wacc;
   } sample_type;

   typedef struct {
      longint b[8];
      bit     fault;
   } envelope_type;

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   reg_idx_type        csr_index;
   logic [47:0]        csr_data;
   logic               req_valid;
   logic               req_ready;
   logic signed [47:0] req_actual_position;
   logic               req_position_valid;
   logic signed [47:0] req_actual_velocity;
   logic               req_velocity_valid;
   logic signed [47:0] req_last_cmd_position;
   logic signed [47:0] req_last_cmd_velocity;
   logic               req_last_velocity_valid;
   logic signed [47:0] req_wanted_velocity;
   logic signed [47:0] req_wanted_acceleration;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [47:0] rsp_pos_low;
   logic signed [47:0] rsp_pos_high;
   logic signed [47:0] rsp_vel_low;
   logic signed [47:0] rsp_vel_high;
   logic signed [47:0] rsp_eff_low;
   logic signed [47:0] rsp_eff_high;
   logic signed [47:0] rsp_acc_low;
   logic signed [47:0] rsp_acc_high;
   logic               rsp_position_fault;

   longint lim_minpos, lim_maxpos, lim_maxvel, lim_maxacc, lim_maxdec, lim_maxeff;
   longint lim_period, lim_enables;

   envelope_type expected_envelopes[$];
   int        error_count;
   int        burst_left;
   int        hold_request;
   int        recv_mode;

   joint_command_limit_envelope dut (.*);

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------- predictor
   function automatic longint sat_q(longint v);
      if (v > Q_MAX)
         return Q_MAX;
      if (v < Q_MIN)
         return Q_MIN;
      return v;
   endfunction

   function automatic longint mul_period(longint a, longint b);
      logic [95:0] p;
      p = ({32'd0, a} * {32'd0, b}) >> 24;
      if (p > 96'(MAG_MAX))
         return Q_MAX;
      return longint'(p);
   endfunction

   function automatic longint div_period(longint n, longint d);
      logic [95:0] mag;
      logic [95:0] q;
      mag = (n < 0) ? 96'(-n) : 96'(n);
      if (mag == 0)
         return 0;
      if (d == 0)
         return (n < 0) ? Q_MIN : Q_MAX;
      q = (mag << 24) / 96'(d);
      if (n < 0)
         return (q > 96'(MAG_MAX) + 1) ? Q_MIN : -longint'(q);
      return (q > 96'(MAG_MAX)) ? Q_MAX : longint'(q);
   endfunction

   function automatic void order_pair(ref longint lo, ref longint hi);
      longint t;
      if (lo > hi) begin
         t  = lo;
         lo = hi;
         hi = t;
      end
   endfunction

   function automatic envelope_type predict_envelope(sample_type s);
      envelope_type e;
      bit     enp, env, ena, endc, ene;
      longint plo, phi, vlo, vhi, elo, ehi, alo, ahi;
      longint avabs, dvel, mv, dp, nlo, nhi, dv;
      enp  = lim_enables[EN_POS];
      env  = lim_enables[EN_VEL];
      ena  = lim_enables[EN_ACC];
      endc = lim_enables[EN_DEC];
      ene  = lim_enables[EN_EFF];
      e.fault = s.pv && enp && (s.apos > lim_maxpos + FAULT_MARGIN ||
                                s.apos < lim_minpos - FAULT_MARGIN);
      plo = lim_minpos;
      phi = lim_maxpos;
      if (env) begin
         avabs = s.vv ? ((s.avel < 0) ? -s.avel : s.avel) : 0;
         dvel  = ena ? sat_q(avabs + mul_period(lim_maxacc, lim_period)) : lim_maxvel;
         mv    = (lim_maxvel < dvel) ? lim_maxvel : dvel;
         dp    = mul_period((mv < 0) ? 0 : mv, lim_period);
         nlo   = s.lpos - dp;
         nlo   = (nlo < phi) ? nlo : phi;
         nlo   = (nlo > plo) ? nlo : plo;
         nhi   = s.lpos + dp;
         nhi   = (nhi > plo) ? nhi : plo;
         nhi   = (nhi < phi) ? nhi : phi;
         plo   = nlo;
         phi   = nhi;
      end
      order_pair(plo, phi);

      vhi = env ? lim_maxvel : Q_MAX;
      vlo = env ? -lim_maxvel : Q_MIN;
      if (enp && s.pv) begin
         nlo = div_period(lim_minpos - s.apos, lim_period);
         nhi = div_period(lim_maxpos - s.apos, lim_period);
         vlo = (nlo > vlo) ? nlo : vlo;
         vhi = (nhi < vhi) ? nhi : vhi;
         if (s.apos > lim_maxpos || s.apos < lim_minpos) begin
            if ((s.apos < lim_maxpos + BOUNDS_MARGIN && s.apos > lim_minpos && s.wvel >= 0) ||
                (s.apos > lim_minpos - BOUNDS_MARGIN && s.apos < lim_maxpos && s.wvel <= 0))
            begin
               vlo = 0;
               vhi = 0;
            end else if (s.apos > lim_maxpos + BOUNDS_MARGIN ||
                         s.apos < lim_minpos - BOUNDS_MARGIN) begin
               vlo = 0;
               vhi = 0;
            end
         end
      end
      if (ena && s.lvv) begin
         dv  = mul_period(lim_maxacc, lim_period);
         vlo = sat_q((s.lvel - dv > vlo) ? s.lvel - dv : vlo);
         vhi = sat_q((s.lvel + dv < vhi) ? s.lvel + dv : vhi);
      end
      order_pair(vlo, vhi);

      ehi = ene ? lim_maxeff : Q_MAX;
      elo = ene ? -lim_maxeff : Q_MIN;
      if (enp && s.pv && s.vv) begin
         if (s.apos <= lim_minpos && s.avel <= 0)
            elo = 0;
         else if (s.apos >= lim_maxpos && s.avel >= 0)
            ehi = 0;
      end
      if (env && s.vv) begin
         if (s.avel < -lim_maxvel)
            elo = 0;
         else if (s.avel > lim_maxvel)
            ehi = 0;
      end
      order_pair(elo, ehi);

      alo = Q_MIN;
      ahi = Q_MAX;
      if (endc && s.vv && ((s.wacc < 0 && s.avel > 0) || (s.wacc > 0 && s.avel < 0))) begin
         alo = -lim_maxdec;
         ahi = lim_maxdec;
      end else if (ena) begin
         alo = -lim_maxacc;
         ahi = lim_maxacc;
      end
      order_pair(alo, ahi);

      e.b[0] = sat_q(plo);
      e.b[1] = sat_q(phi);
      e.b[2] = sat_q(vlo);
      e.b[3] = sat_q(vhi);
      e.b[4] = sat_q(elo);
      e.b[5] = sat_q(ehi);
      e.b[6] = sat_q(alo);
      e.b[7] = sat_q(ahi);
      return e;
   endfunction

   // ---------------------------------------------------------------- drivers
   function automatic longint rand_q();
      logic [47:0] v;
      v = 48'({$urandom, $urandom});
      return longint'($signed(v));
   endfunction

   function automatic longint rand_mag();
      logic [46:0] v;
      v = 47'({$urandom, $urandom});
      return longint'(v);
   endfunction

   function automatic longint rand_near(longint base);
      return sat_q(base + $signed($urandom_range(0, 6 * 16777)) - 3 * 16777);
   endfunction

   function automatic longint rand_speed();
      case ($urandom_range(0, 4))
         0: return rand_q();
         1: return 0;
         default: return longint'($signed($urandom_range(0, 32'h7FFF_FFFF))) -
                         64'sd1073741824;
      endcase
   endfunction

   task automatic write_reg(reg_idx_type idx, longint value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value[47:0];
      do
         @(posedge clock);
      while (!csr_ready);
      case (idx)
         REG_MIN_POS: lim_minpos  = longint'($signed(value[47:0]));
         REG_MAX_POS: lim_maxpos  = longint'($signed(value[47:0]));
         REG_MAX_VEL: lim_maxvel  = value & MAG_MAX;
         REG_MAX_ACC: lim_maxacc  = value & MAG_MAX;
         REG_MAX_DEC: lim_maxdec  = value & MAG_MAX;
         REG_MAX_EFF: lim_maxeff  = value & MAG_MAX;
         REG_PERIOD:  lim_period  = value & MAG_MAX;
         REG_ENABLES: lim_enables = value & 31;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_limits(longint minp, longint maxp, longint vel, longint acc,
                             longint dec, longint eff, longint per, longint en);
      write_reg(REG_MIN_POS, minp);
      write_reg(REG_MAX_POS, maxp);
      write_reg(REG_MAX_VEL, vel);
      write_reg(REG_MAX_ACC, acc);
      write_reg(REG_MAX_DEC, dec);
      write_reg(REG_MAX_EFF, eff);
      write_reg(REG_PERIOD, per);
      write_reg(REG_ENABLES, en);
   endtask

   task automatic send_sample(sample_type s, bit gaps);
      int gap;
      if (gaps && burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      if (burst_left > 0)
         burst_left--;
      req_valid               <= 1'b1;
      req_actual_position     <= s.apos[47:0];
      req_position_valid      <= s.pv;
      req_actual_velocity     <= s.avel[47:0];
      req_velocity_valid      <= s.vv;
      req_last_cmd_position   <= s.lpos[47:0];
      req_last_cmd_velocity   <= s.lvel[47:0];
      req_last_velocity_valid <= s.lvv;
      req_wanted_velocity     <= s.wvel[47:0];
      req_wanted_acceleration <= s.wacc[47:0];
      do
         @(posedge clock);
      while (!req_ready);
      expected_envelopes.push_back(predict_envelope(s));
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      wait (expected_envelopes.size() == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic sample_type random_sample();
      sample_type s;
      case ($urandom_range(0, 4))
         0, 1: s.apos = rand_near(lim_minpos);
         2, 3: s.apos = rand_near(lim_maxpos);
         default: s.apos = rand_q();
      endcase
      s.pv   = ($urandom_range(0, 7) != 0);
      s.avel = rand_speed();
      s.vv   = ($urandom_range(0, 7) != 0);
      s.lpos = ($urandom_range(0, 3) == 0) ? rand_q() :
               rand_near(($urandom_range(0, 1) == 0) ? lim_minpos : lim_maxpos);
      s.lvel = rand_speed();
      s.lvv  = ($urandom_range(0, 7) != 0);
      s.wvel = rand_speed();
      s.wacc = rand_speed();
      return s;
   endfunction

   function automatic sample_type make_sample(longint ap, bit pv, longint av, bit vv,
                                              longint lp, longint lv, bit lvv,
                                              longint wv, longint wa);
      sample_type s;
      s.apos = ap; s.pv = pv; s.avel = av; s.vv = vv; s.lpos = lp;
      s.lvel = lv; s.lvv = lvv; s.wvel = wv; s.wacc = wa;
      return s;
   endfunction

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      envelope_type e;
      longint    got[8];
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_pos_low, rsp_pos_high, rsp_vel_low, rsp_vel_high,
                 rsp_eff_low, rsp_eff_high, rsp_acc_low, rsp_acc_high};
         if (expected_envelopes.size() == 0) begin
            $display("%0t: unexpected item on rsp", $time);
            error_count++;
         end else begin
            e = expected_envelopes.pop_front();
            for (int i = 0; i < 8; i++)
               if (got[i] != e.b[i]) begin
                  $display("%0t: bound %0d expected %0d got %0d", $time, i, e.b[i], got[i]);
                  error_count++;
               end
            if (rsp_position_fault !== e.fault) begin
               $display("%0t: fault expected %0b got %0b", $time, e.fault,
                        rsp_position_fault);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- receiver
   always @(negedge clock) begin
      static int holding = 0;
      static int phase = 0;
      if (hold_request > 0) begin
         holding      = hold_request;
         hold_request = 0;
      end
      phase++;
      if (phase % 400 == 0)
         recv_mode = $urandom_range(0, 3);
      if (holding > 0) begin
         holding--;
         rsp_ready <= 1'b0;
      end else begin
         case (recv_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 1) == 0);
            2: rsp_ready <= ($urandom_range(0, 7) != 0);
            default: rsp_ready <= (phase % 5 < 2);
         endcase
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_reset_defaults();
      for (int i = 0; i < 6; i++)
         send_sample(random_sample(), 1'b1);
      drain();
   endtask

   task automatic test_directed_extremes();
      set_limits(-64'sd16777216, 64'sd16777216, 64'sd33554432, 64'sd8388608,
                 64'sd4194304, 64'sd50331648, 64'sd16777, 31);
      send_sample(make_sample(Q_MAX, 1, Q_MAX, 1, Q_MAX, Q_MAX, 1, Q_MAX, Q_MAX), 0);
      send_sample(make_sample(Q_MIN, 1, Q_MIN, 1, Q_MIN, Q_MIN, 1, Q_MIN, Q_MIN), 0);
      send_sample(make_sample(0, 0, 0, 0, 0, 0, 0, 0, 0), 0);
      // at each edge, just beyond, beyond the fault margin
      send_sample(make_sample(16777216, 1, 100, 1, 0, 0, 1, 0, -5), 0);
      send_sample(make_sample(-16777216, 1, -100, 1, 0, 0, 1, 0, 5), 0);
      send_sample(make_sample(16777216 + 100, 1, 0, 1, 0, 0, 1, 5, 0), 0);
      send_sample(make_sample(16777216 + 100, 1, 0, 1, 0, 0, 1, -5, 0), 0);
      send_sample(make_sample(-16777216 - 100, 1, 0, 1, 0, 0, 1, -5, 0), 0);
      send_sample(make_sample(-16777216 - 100, 1, 0, 1, 0, 0, 1, 5, 0), 0);
      send_sample(make_sample(16777216 + 16778, 1, 5, 1, 0, 0, 0, 0, 0), 0);
      send_sample(make_sample(-16777216 - 16778, 1, -5, 1, 0, 0, 0, 0, 0), 0);
      // velocity beyond limit each way, decel case each way
      send_sample(make_sample(0, 1, 64'sd40000000, 1, 0, 0, 1, 0, -1), 0);
      send_sample(make_sample(0, 1, -64'sd40000000, 1, 0, 0, 1, 0, 1), 0);
      send_sample(make_sample(0, 0, -64'sd40000000, 0, 0, 0, 0, 0, 1), 0);
      drain();
      // reversed limits, tiny period, large magnitudes
      set_limits(64'sd16777216, -64'sd16777216, MAG_MAX, MAG_MAX, 0, MAG_MAX, 1, 31);
      send_sample(make_sample(0, 1, 0, 1, 0, 0, 1, 0, 0), 0);
      send_sample(make_sample(Q_MAX, 1, Q_MIN, 1, Q_MAX, Q_MIN, 1, 1, 1), 0);
      send_sample(make_sample(Q_MIN, 1, Q_MAX, 1, Q_MIN, Q_MAX, 1, -1, -1), 0);
      drain();
      // maximum period, extreme position limits
      set_limits(Q_MIN, Q_MAX, 1, MAG_MAX, MAG_MAX, 0, MAG_MAX, 31);
      send_sample(make_sample(Q_MAX, 1, Q_MAX, 1, 0, Q_MAX, 1, Q_MAX, Q_MIN), 0);
      send_sample(make_sample(Q_MIN, 1, -1, 1, Q_MIN, Q_MIN, 1, Q_MIN, 1), 0);
      send_sample(make_sample(0, 1, 1, 1, Q_MAX, 0, 1, 0, -1), 0);
      drain();
   endtask

   task automatic test_backpressure();
      set_limits(-64'sd33554432, 64'sd33554432, 64'sd16777216, 64'sd16777216,
                 64'sd8388608, 64'sd16777216, 64'sd167772, 31);
      hold_request = 400;
      for (int i = 0; i < 150; i++)
         send_sample(random_sample(), 1'b0);
      drain();
   endtask

   task automatic test_random_phases(int phases, int per_phase);
      longint a, b;
      for (int p = 0; p < phases; p++) begin
         a = ($urandom_range(0, 3) == 0) ? rand_q() :
             longint'($signed($urandom_range(0, 32'hFFFF_FFFF))) * 64;
         b = ($urandom_range(0, 3) == 0) ? rand_q() :
             a + longint'($urandom_range(0, 32'h3FFF_FFFF)) * 4;
         set_limits(a, sat_q(b),
                    ($urandom_range(0, 4) == 0) ? rand_mag() : $urandom_range(0, 32'h7FFF_FFFF),
                    ($urandom_range(0, 4) == 0) ? rand_mag() : $urandom_range(0, 32'h7FFF_FFFF),
                    ($urandom_range(0, 4) == 0) ? rand_mag() : $urandom_range(0, 32'h7FFF_FFFF),
                    ($urandom_range(0, 4) == 0) ? rand_mag() : $urandom_range(0, 32'h7FFF_FFFF),
                    ($urandom_range(0, 4) == 0) ? rand_mag() + 1 : $urandom_range(1, 2000000),
                    ($urandom_range(0, 2) == 0) ? 31 : $urandom_range(0, 31));
         for (int i = 0; i < per_phase; i++)
            send_sample(random_sample(), 1'b1);
         drain();
      end
   endtask

   initial begin
      reset                   = 1'b1;
      csr_valid               = 1'b0;
      csr_index               = REG_MIN_POS;
      csr_data                = '0;
      req_valid               = 1'b0;
      req_actual_position     = '0;
      req_position_valid      = 1'b0;
      req_actual_velocity     = '0;
      req_velocity_valid      = 1'b0;
      req_last_cmd_position   = '0;
      req_last_cmd_velocity   = '0;
      req_last_velocity_valid = 1'b0;
      req_wanted_velocity     = '0;
      req_wanted_acceleration = '0;
      rsp_ready               = 1'b0;
      error_count             = 0;
      burst_left              = 0;
      hold_request            = 0;
      recv_mode               = 0;
      lim_minpos = 0; lim_maxpos = 0; lim_maxvel = 0; lim_maxacc = 0;
      lim_maxdec = 0; lim_maxeff = 0; lim_period = 16777; lim_enables = 0;
      repeat (10) @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_directed_extremes();
      test_backpressure();
      test_random_phases(10, 110);

      if (error_count == 0)
         $display("joint_command_limit_envelope test passed");
      else
         $display("joint_command_limit_envelope test failed");
      $finish;
   end

   initial begin
      #3000000;
      $display("joint_command_limit_envelope test failed");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/jcle_pkg.sv
rtl/joint_command_limit_envelope.sv
rtl/jcle_checker.sv
verif/joint_command_limit_envelope_tb.sv
